>>> hdl/mf3_pkg.sv
// Shared types and constants of the 3x3 RGB median filter.
package mf3_pkg;

  // Fixed field widths.
  localparam int unsigned CHANNEL_BITS    = 8;
  localparam int unsigned WIDTH_REG_BITS  = 11;
  localparam int unsigned HEIGHT_REG_BITS = 12;
  localparam int unsigned CFG_DATA_BITS   = 12;
  localparam int unsigned ROW_BITS        = 12;

  // Result queue sizing.
  localparam int unsigned OFIFO_DEPTH    = 8;
  localparam int unsigned OFIFO_PTR_BITS = $clog2(OFIFO_DEPTH);
  localparam int unsigned OFIFO_CNT_BITS = $clog2(OFIFO_DEPTH + 1);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } pixel_t;

  // One line buffer entry: the pixel two rows up and the pixel one row up.
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } line_pair_t;

  // Neighborhood, indexed [column][row]; column 0 is the oldest.
  typedef pixel_t [2:0][2:0] window_t;

  // Input word.
  typedef struct packed {
    logic  cmd;
    chan_t red_in;
    chan_t green_in;
    chan_t blue_in;
  } mf3_in_t;

  // Output word.
  typedef struct packed {
    chan_t red_out;
    chan_t green_out;
    chan_t blue_out;
    logic  last_of_image;
  } mf3_out_t;

  // Per-word control that rides along with the sorting pipeline.
  typedef struct packed {
    logic   use_median;
    logic   last;
    pixel_t pass;
  } mf3_ctrl_t;

endpackage

>>> hdl/mf3_line_buf.sv
// Two-row line buffer with registered read and write-to-read forwarding.
module mf3_line_buf import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output line_pair_t    rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  line_pair_t    wr_data_i
);

  line_pair_t mem_q [MAX_WIDTH];
  line_pair_t rd_raw_q;
  line_pair_t fwd_data_q;
  logic       fwd_q;

  // Storage: read-first, one read and one write port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_raw_q   <= mem_q[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // A read that lands on the entry being written in the same cycle takes the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_raw_q;

endmodule

>>> hdl/mf3_median9.sv
// Two-stage median-of-nine sorting network, one network per color channel.
module mf3_median9 import mf3_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  mf3_ctrl_t ctrl_i,
  input  window_t   window_i,
  output logic      valid_o,
  output mf3_out_t  data_o
);

  typedef logic [8:0][CHANNEL_BITS-1:0] chan_vec_t;

  // Compare and exchange: the lower value ends up at position a.
  function automatic chan_vec_t cas(chan_vec_t v, logic [3:0] a, logic [3:0] b);
    chan_vec_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  // First half: sort each group of three.
  function automatic chan_vec_t sort_groups(chan_vec_t v);
    chan_vec_t r;
    r = v;
    r = cas(r, 4'd1, 4'd2);
    r = cas(r, 4'd4, 4'd5);
    r = cas(r, 4'd7, 4'd8);
    r = cas(r, 4'd0, 4'd1);
    r = cas(r, 4'd3, 4'd4);
    r = cas(r, 4'd6, 4'd7);
    r = cas(r, 4'd1, 4'd2);
    r = cas(r, 4'd4, 4'd5);
    r = cas(r, 4'd7, 4'd8);
    return r;
  endfunction

  // Second half: merge the sorted groups down to the middle value.
  function automatic chan_t pick_median(chan_vec_t v);
    chan_vec_t r;
    r = v;
    r = cas(r, 4'd0, 4'd3);
    r = cas(r, 4'd5, 4'd8);
    r = cas(r, 4'd4, 4'd7);
    r = cas(r, 4'd3, 4'd6);
    r = cas(r, 4'd1, 4'd4);
    r = cas(r, 4'd2, 4'd5);
    r = cas(r, 4'd4, 4'd7);
    r = cas(r, 4'd4, 4'd2);
    r = cas(r, 4'd6, 4'd4);
    r = cas(r, 4'd4, 4'd2);
    return r[4];
  endfunction

  pixel_t [8:0] flat;
  chan_vec_t    red_a, green_a, blue_a;
  chan_vec_t    red_q, green_q, blue_q;
  mf3_ctrl_t    ctrl_q;
  logic         valid_q;

  // Split the window into per-channel vectors and run the first half.
  always_comb begin
    flat = window_i;
    for (int i = 0; i < 9; i++) begin
      red_a[i]   = flat[i].red;
      green_a[i] = flat[i].green;
      blue_a[i]  = flat[i].blue;
    end
  end

  always_ff @(posedge clk_i) begin
    red_q   <= sort_groups(red_a);
    green_q <= sort_groups(green_a);
    blue_q  <= sort_groups(blue_a);
    ctrl_q  <= ctrl_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Second half and the choice between median and pass-through.
  always_comb begin
    if (ctrl_q.use_median) begin
      data_o.red_out   = pick_median(red_q);
      data_o.green_out = pick_median(green_q);
      data_o.blue_out  = pick_median(blue_q);
    end else begin
      data_o.red_out   = ctrl_q.pass.red;
      data_o.green_out = ctrl_q.pass.green;
      data_o.blue_out  = ctrl_q.pass.blue;
    end
    data_o.last_of_image = ctrl_q.last;
  end

  assign valid_o = valid_q;

endmodule

>>> hdl/mf3_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
module mf3_out_fifo import mf3_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  mf3_out_t                  push_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output mf3_out_t                  out_data_o,
  output logic [OFIFO_CNT_BITS-1:0] count_o
);

  mf3_out_t                  fifo_q [OFIFO_DEPTH];
  logic [OFIFO_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [OFIFO_CNT_BITS-1:0] count_q;
  logic                      pop;

  assign pop = out_valid_o && out_ready_i;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + OFIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + OFIFO_PTR_BITS'(1);
      end
      if (push_i && !pop) begin
        count_q <= count_q + OFIFO_CNT_BITS'(1);
      end else if (pop && !push_i) begin
        count_q <= count_q - OFIFO_CNT_BITS'(1);
      end
    end
  end

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = fifo_q[rd_ptr_q];
  assign count_o     = count_q;

endmodule

>>> hdl/median_filter_3x3_rgb.sv
// Top level of the 3x3 RGB median filter.
//
// The block takes one word per clock, a pixel or a flush tick, and keeps that rate as long
// as the output side drains. A word passes the line buffer read, the window register and a
// two-stage sorting network before its result is written to the output queue. Input ready
// depends only on the eight-entry output queue: it drops when the queue plus the words still
// in the pipeline could fill it. Results trail the pixels by one row plus one pixel; after
// the last pixel of an image, flush ticks drain the rest of the image, one result per tick,
// from the line buffer. The line buffer is not cleared at reset and needs no setup time.
// Writing either size register restarts the image counters; do so only while no word is
// in flight.
module median_filter_3x3_rgb import mf3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  mf3_in_t                  in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output mf3_out_t                 out_data_o,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WCMP = (CW + 1 > WIDTH_REG_BITS) ? CW + 1 : WIDTH_REG_BITS;
  localparam int unsigned W_RESET      = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
  localparam int unsigned W_RESET_LAST = W_RESET - 1;
  localparam int unsigned H_RESET_LAST = 479;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_e;

  // Configuration, held as last column and last row.
  logic [CW-1:0]       w_last_q;
  logic [ROW_BITS-1:0] h_last_q;
  logic [CW-1:0]       w_last_cfg;
  logic [ROW_BITS-1:0] h_last_cfg;
  logic [WIDTH_REG_BITS-1:0]  w_raw;
  logic [WCMP-1:0]            w_ext;
  logic [HEIGHT_REG_BITS-1:0] h_raw;

  // Raster position counters.
  logic [CW-1:0]       in_column_q, in_column_d, out_column_q, out_column_d;
  logic [ROW_BITS-1:0] in_row_q, in_row_d, out_row_q, out_row_d;

  // Decode of the incoming word.
  logic                in_fire, is_flush, img_done;
  logic [CW-1:0]       pc, poc, base_c, adv_c, rd_addr;
  logic [ROW_BITS-1:0] pr, por, base_r, adv_r;
  logic                pix_emit, pix_interior, flush_res, res0, last0;

  // Stage 1: line buffer read in flight.
  logic          s1_pix_q, s1_res_q, s1_median_q, s1_last_q, s1_bottom_q;
  pixel_t        s1_px_q;
  logic [CW-1:0] s1_addr_q;
  line_pair_t    rd_data, wr_data;

  // Stage 2: window holds the neighborhood of the word.
  window_t   window_q;
  logic      s2_res_q;
  mf3_ctrl_t s2_ctrl_q;
  pixel_t    pass1;

  // Sorting and output queue.
  logic                      s3_valid;
  mf3_out_t                  s3_data;
  logic [OFIFO_CNT_BITS-1:0] fifo_count;
  logic [OFIFO_CNT_BITS:0]   occ;

  // Register writes: clamp the width to the buffer and treat zero sizes as one.
  always_comb begin
    w_raw = cfg_data_i[WIDTH_REG_BITS-1:0];
    h_raw = cfg_data_i[HEIGHT_REG_BITS-1:0];
    w_ext = WCMP'(w_raw);
    if (w_raw == '0) begin
      w_last_cfg = '0;
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_last_cfg = CW'(MAX_WIDTH - 1);
    end else begin
      w_last_cfg = CW'(w_ext - WCMP'(1));
    end
    h_last_cfg = (h_raw == '0) ? '0 : ROW_BITS'(h_raw - HEIGHT_REG_BITS'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= CW'(W_RESET_LAST);
      h_last_q <= ROW_BITS'(H_RESET_LAST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  w_last_q <= w_last_cfg;
        CFG_IMAGE_HEIGHT: h_last_q <= h_last_cfg;
        default: ;
      endcase
    end
  end

  // Room check: every word that may still produce a result has a queue slot reserved.
  assign occ = (OFIFO_CNT_BITS + 1)'(fifo_count) + (OFIFO_CNT_BITS + 1)'(s1_res_q)
             + (OFIFO_CNT_BITS + 1)'(s2_res_q) + (OFIFO_CNT_BITS + 1)'(s3_valid);
  assign in_ready_o = (occ < (OFIFO_CNT_BITS + 1)'(OFIFO_DEPTH));
  assign in_fire    = in_valid_i && in_ready_o;

  // Word decode. A pixel after a complete image starts a new one.
  always_comb begin
    is_flush = (in_data_i.cmd == CMD_FLUSH);
    img_done = (in_row_q > h_last_q);
    if (img_done) begin
      pc  = '0;
      pr  = '0;
      poc = '0;
      por = '0;
    end else begin
      pc  = in_column_q;
      pr  = in_row_q;
      poc = out_column_q;
      por = out_row_q;
    end
    pix_emit     = (pr >= ROW_BITS'(2)) || ((pr == ROW_BITS'(1)) && (pc >= CW'(1)));
    pix_interior = (pr >= ROW_BITS'(2)) && (pc >= CW'(2));
    flush_res    = img_done && (out_row_q <= h_last_q);
    base_c       = is_flush ? out_column_q : poc;
    base_r       = is_flush ? out_row_q : por;
    res0         = is_flush ? flush_res : pix_emit;
    last0        = (base_r == h_last_q) && (base_c == w_last_q);
    rd_addr      = is_flush ? out_column_q : pc;
    if (base_c == w_last_q) begin
      adv_c = '0;
      adv_r = base_r + ROW_BITS'(1);
    end else begin
      adv_c = base_c + CW'(1);
      adv_r = base_r;
    end
  end

  // Counter update.
  always_comb begin
    in_column_d  = in_column_q;
    in_row_d     = in_row_q;
    out_column_d = out_column_q;
    out_row_d    = out_row_q;
    if (cfg_we_i) begin
      in_column_d  = '0;
      in_row_d     = '0;
      out_column_d = '0;
      out_row_d    = '0;
    end else if (in_fire) begin
      if (!is_flush) begin
        if (pc == w_last_q) begin
          in_column_d = '0;
          in_row_d    = pr + ROW_BITS'(1);
        end else begin
          in_column_d = pc + CW'(1);
          in_row_d    = pr;
        end
        out_column_d = poc;
        out_row_d    = por;
      end
      if (res0) begin
        out_column_d = adv_c;
        out_row_d    = adv_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_column_q  <= '0;
      in_row_q     <= '0;
      out_column_q <= '0;
      out_row_q    <= '0;
    end else begin
      in_column_q  <= in_column_d;
      in_row_q     <= in_row_d;
      out_column_q <= out_column_d;
      out_row_q    <= out_row_d;
    end
  end

  // Stage 1 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_pix_q <= 1'b0;
      s1_res_q <= 1'b0;
    end else begin
      s1_pix_q <= in_fire && !is_flush;
      s1_res_q <= in_fire && res0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_median_q <= !is_flush && pix_interior;
      s1_last_q   <= last0;
      s1_bottom_q <= is_flush && (out_row_q == h_last_q);
      s1_px_q     <= '{red: in_data_i.red_in, green: in_data_i.green_in,
                       blue: in_data_i.blue_in};
      s1_addr_q   <= pc;
    end
  end

  // Line buffer: each pixel pushes the column up by one row.
  assign wr_data = '{older: rd_data.newer, newer: s1_px_q};

  mf3_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_pix_q),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data)
  );

  // Window shift on every pixel; the new column is top, middle and the pixel itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (s1_pix_q) begin
      window_q[0]    <= window_q[1];
      window_q[1]    <= window_q[2];
      window_q[2][0] <= rd_data.older;
      window_q[2][1] <= rd_data.newer;
      window_q[2][2] <= s1_px_q;
    end
  end

  // Pass-through value: the center after the shift, or the buffered row for a flush.
  always_comb begin
    if (s1_pix_q) begin
      pass1 = window_q[2][1];
    end else if (s1_bottom_q) begin
      pass1 = rd_data.newer;
    end else begin
      pass1 = rd_data.older;
    end
  end

  // Stage 2 registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_res_q <= 1'b0;
    end else begin
      s2_res_q <= s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_ctrl_q <= '{use_median: s1_median_q, last: s1_last_q, pass: pass1};
  end

  // Sorting network and result queue.
  mf3_median9 u_median9 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s2_res_q),
    .ctrl_i   (s2_ctrl_q),
    .window_i (window_q),
    .valid_o  (s3_valid),
    .data_o   (s3_data)
  );

  mf3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid),
    .push_data_i (s3_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .count_o     (fifo_count)
  );

endmodule
